// ----- rtl/hse_pkg.sv -----
// Package for the heap sort engine: item types, controller states,
// datapath command codes and status flags. No dependencies.
`default_nettype none

package hse_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflowed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_BLD_NEXT,
    ST_SWAP_RD,
    ST_SWAP_LD,
    ST_SORT_NEXT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_RD_NODE,
    OP_LD_NODE,
    OP_RD_KIDS,
    OP_CMP,
    OP_RD_SWAP,
    OP_LD_SWAP,
    OP_IDX_DEC,
    OP_IDX_LAST,
    OP_IDX_CLR,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic n_small;
    logic sift_stop;
    logic idx_zero;
    logic idx_one;
    logic idx_final;
    logic out_free;
  } hse_status_t;

endpackage

`default_nettype wire

// ----- rtl/heap_sort_engine_core.sv -----
// Top level of the heap sort engine: controller plus datapath.
// Depends on hse_pkg, hse_controller and hse_datapath.
//
// Collects a set of signed 32-bit values, one item per cycle, into a store of
// DEPTH entries; an item with last_item set closes the set (values past DEPTH
// are dropped and every result of the set has overflowed set). The block then
// heap sorts the store in place and emits the values in ascending order, with
// last_result on the largest. Input stall is high from the last item until the
// final result sits in the output register. Each sift level is a dual-port
// store read, then a compare and write back; the build runs n/2+1 sifts, each
// set up by a node read and load and followed by an index step, the sort n-1
// sifts set up by a swap read and load, and each result is emitted by a store
// read and an output register load, waiting while the output is stalled.
`default_nettype none

module heap_sort_engine_core #(
  parameter int unsigned DEPTH = hse_pkg::DEPTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  hse_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output hse_pkg::out_item_t out_item_o
);
  import hse_pkg::*;

  op_e         op;
  hse_status_t status;

  hse_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_item),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .op_o       (op)
  );

  hse_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.last_item) |=> in_stall_o)
    else $error("input not stalled after last item");

  a_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_EMIT) |-> !out_valid_o)
    else $error("output register overwritten while holding a result");

  a_no_load_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_CMP || op == OP_LD_SWAP) |-> in_stall_o)
    else $error("input accepted during sort");
`endif

endmodule

`default_nettype wire

// ----- rtl/hse_datapath.sv -----
// Datapath of the heap sort engine: value store, sift-down compare unit,
// index registers and the output register. Depends on hse_pkg.
`default_nettype none

module hse_datapath #(
  parameter int unsigned DEPTH = hse_pkg::DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  hse_pkg::op_e        op_i,
  input  wire                 in_valid_i,
  input  hse_pkg::in_item_t   in_item_i,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output hse_pkg::out_item_t  out_item_o,
  output hse_pkg::hse_status_t status_o
);
  import hse_pkg::*;

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned CW   = IW + 2;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [IW-1:0]     addr_a, addr_b, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  logic [CNTW-1:0]   count_q;
  logic              ovf_q;
  logic [IW-1:0]     idx_q, node_q;
  logic [CNTW-1:0]   len_q;
  logic [DATA_W-1:0] val_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [CW-1:0]     lc, rc;
  logic              lc_ok, rc_ok, a_gt, b_gt, sift_stop;
  logic [DATA_W-1:0] mid_val, top_val;
  logic [IW-1:0]     top_idx;
  logic              in_accept, store_ok, idx_final;

  assign in_accept = in_valid_i && (op_i == OP_LOAD);
  assign store_ok  = count_q < CNTW'(DEPTH);
  assign idx_final = (CNTW'(idx_q) == (count_q - CNTW'(1)));

  assign lc      = {1'b0, node_q, 1'b1};
  assign rc      = lc + CW'(1);
  assign lc_ok   = lc < CW'(len_q);
  assign rc_ok   = rc < CW'(len_q);
  assign a_gt    = lc_ok && ($signed(rd_a_q) > $signed(val_q));
  assign mid_val = a_gt ? rd_a_q : val_q;
  assign b_gt    = rc_ok && ($signed(rd_b_q) > $signed(mid_val));
  assign top_val = b_gt ? rd_b_q : mid_val;
  assign top_idx = b_gt ? rc[IW-1:0] : (a_gt ? lc[IW-1:0] : node_q);
  assign sift_stop = !a_gt && !b_gt;

  always_comb begin
    addr_a  = idx_q;
    addr_b  = idx_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = val_q;
    case (op_i)
      OP_LOAD: begin
        if (in_accept && store_ok) begin
          wr_en   = 1'b1;
          wr_addr = count_q[IW-1:0];
          wr_data = $unsigned(in_item_i.value);
        end
      end
      OP_RD_KIDS: begin
        addr_a = lc[IW-1:0];
        addr_b = rc[IW-1:0];
      end
      OP_CMP: begin
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = sift_stop ? val_q : top_val;
      end
      OP_RD_SWAP: begin
        addr_a = '0;
      end
      OP_LD_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_a_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      node_q  <= '0;
      len_q   <= '0;
    end else begin
      case (op_i)
        OP_LOAD: begin
          if (in_accept) begin
            if (store_ok) begin
              count_q <= count_q + CNTW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        OP_START: begin
          len_q <= count_q;
          idx_q <= IW'(count_q >> 1);
        end
        OP_LD_NODE: begin
          node_q <= idx_q;
        end
        OP_CMP: begin
          if (!sift_stop) begin
            node_q <= top_idx;
          end
        end
        OP_LD_SWAP: begin
          node_q <= '0;
          len_q  <= CNTW'(idx_q);
        end
        OP_IDX_DEC: begin
          idx_q <= idx_q - IW'(1);
        end
        OP_IDX_LAST: begin
          idx_q <= IW'(count_q - CNTW'(1));
        end
        OP_IDX_CLR: begin
          idx_q <= '0;
        end
        OP_EMIT: begin
          if (idx_final) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LD_NODE: val_q <= rd_a_q;
      OP_LD_SWAP: val_q <= rd_b_q;
      OP_EMIT: begin
        out_q.sorted_value <= $signed(rd_a_q);
        out_q.last_result  <= idx_final;
        out_q.overflowed   <= ovf_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.n_small   = count_q < CNTW'(2);
  assign status_o.sift_stop = sift_stop;
  assign status_o.idx_zero  = (idx_q == '0);
  assign status_o.idx_one   = (idx_q == IW'(1));
  assign status_o.idx_final = idx_final;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ----- rtl/hse_controller.sv -----
// Controller of the heap sort engine: load, heap build, sort and emit
// sequencing. Issues datapath commands. Depends on hse_pkg.
`default_nettype none

module hse_controller (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_last_i,
  input  hse_pkg::hse_status_t status_i,
  output logic                 in_stall_o,
  output hse_pkg::op_e         op_o
);
  import hse_pkg::*;

  state_e state_q, state_d;
  logic   sort_q, sort_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      sort_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sort_q  <= sort_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sort_d  = sort_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        sort_d  = 1'b0;
        state_d = status_i.n_small ? ST_EMIT_RD : ST_BLD_RD;
      end
      ST_BLD_RD:  state_d = ST_BLD_LD;
      ST_BLD_LD:  state_d = ST_SIFT_RD;
      ST_SIFT_RD: state_d = ST_SIFT_CMP;
      ST_SIFT_CMP: begin
        if (status_i.sift_stop) begin
          state_d = sort_q ? ST_SORT_NEXT : ST_BLD_NEXT;
        end else begin
          state_d = ST_SIFT_RD;
        end
      end
      ST_BLD_NEXT: begin
        if (status_i.idx_zero) begin
          sort_d  = 1'b1;
          state_d = ST_SWAP_RD;
        end else begin
          state_d = ST_BLD_RD;
        end
      end
      ST_SWAP_RD: state_d = ST_SWAP_LD;
      ST_SWAP_LD: state_d = ST_SIFT_RD;
      ST_SORT_NEXT: begin
        if (status_i.idx_one) begin
          sort_d  = 1'b0;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_SWAP_RD;
        end
      end
      ST_EMIT_RD: begin
        if (status_i.out_free) begin
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_d = status_i.idx_final ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD: begin
        op_o       = OP_LOAD;
        in_stall_o = 1'b0;
      end
      ST_START:    op_o = OP_START;
      ST_BLD_RD:   op_o = OP_RD_NODE;
      ST_BLD_LD:   op_o = OP_LD_NODE;
      ST_SIFT_RD:  op_o = OP_RD_KIDS;
      ST_SIFT_CMP: op_o = OP_CMP;
      ST_BLD_NEXT: op_o = status_i.idx_zero ? OP_IDX_LAST : OP_IDX_DEC;
      ST_SWAP_RD:  op_o = OP_RD_SWAP;
      ST_SWAP_LD:  op_o = OP_LD_SWAP;
      ST_SORT_NEXT: op_o = status_i.idx_one ? OP_IDX_CLR : OP_IDX_DEC;
      ST_EMIT_RD:  op_o = status_i.out_free ? OP_RD_NODE : OP_NONE;
      ST_EMIT_LD:  op_o = OP_EMIT;
      default:     op_o = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/sv/heap_sort_engine_core_tb.sv -----
// Self-checking testbench for heap_sort_engine_core: feeds sets of signed values,
// predicts the ascending output of every set and checks each emitted result.
// Depends on hse_pkg and the heap_sort_engine_core RTL.
module heap_sort_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  localparam int unsigned          CYCLE_LIMIT = 300000;
  localparam int unsigned          HOLD_CYCLES = 600;
  localparam int unsigned          ITEM_TARGET = 270;
  localparam logic signed [31:0]   VAL_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0]   VAL_MAX     = 32'sh7FFF_FFFF;

  class sorted_set_tracker;
    logic signed [31:0] set_values[$];
    bit                 dropped;
    out_item_t          ascending_q[$];
    int unsigned        errors;

    function void add_value(in_item_t it);
      logic signed [31:0] key;
      out_item_t          r;
      int                 i;
      int                 j;
      int                 n;
      if (set_values.size() < DEPTH_DEF) begin
        set_values.push_back(it.value);
      end else begin
        dropped = 1'b1;
      end
      if (!it.last_item) return;
      n = set_values.size();
      for (i = 1; i < n; i++) begin
        key = set_values[i];
        j = i - 1;
        while (j >= 0 && set_values[j] > key) begin
          set_values[j+1] = set_values[j];
          j--;
        end
        set_values[j+1] = key;
      end
      for (i = 0; i < n; i++) begin
        r.sorted_value = set_values[i];
        r.last_result  = (i == n - 1);
        r.overflowed   = dropped;
        ascending_q.push_back(r);
      end
      set_values.delete();
      dropped = 1'b0;
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (ascending_q.size() == 0) begin
        $error("unexpected item: sorted_value %0d", got.sorted_value);
        errors++;
        return;
      end
      want = ascending_q.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
        errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return ascending_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  sorted_set_tracker tracker = new;
  bit                send_burst;
  bit                recv_burst;
  bit                hold_req;
  int unsigned       items_sent;

  heap_sort_engine_core #(
    .DEPTH(DEPTH_DEF)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MIN + $urandom_range(0, 3);
      1:       return VAL_MAX - $urandom_range(0, 3);
      2, 3:    return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_value(input logic signed [31:0] v, input bit last);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{value: v, last_item: last};
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.add_value(in_item);
    items_sent++;
  endtask

  task automatic send_random_set(input int n);
    int k;
    send_burst = ($urandom_range(0, 2) == 0);
    for (k = 0; k < n; k++) begin
      send_value(pick_value(), k == n - 1);
    end
  endtask

  // hold the input low and let every pending result drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int k;
    items_sent = 0;
    send_burst = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b1);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b1);
    for (k = 0; k < 3; k++) send_value(32'sd7, k == 2);
    send_burst = 1'b1;
    for (k = 4; k >= 0; k--) send_value(k, k == 0);
    drain();

    hold_req = 1'b1;
    send_random_set(12);
    send_random_set(6);
    send_random_set(DEPTH_DEF);
    send_random_set(DEPTH_DEF + 2);
    drain();
    while (items_sent < ITEM_TARGET) begin
      send_random_set($urandom_range(1, 10));
    end
    drain();
    repeat (50) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken      = 0;
    recv_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 16 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_output(out_item);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- heap_sort_engine_core.f -----
rtl/hse_pkg.sv
rtl/hse_datapath.sv
rtl/hse_controller.sv
rtl/heap_sort_engine_core.sv
tb/sv/heap_sort_engine_core_tb.sv
